### sv/mpn_pkg.sv
// Shared types, codes and constants of the MIDI preset navigator.
package mpn_pkg;

  // Request codes
  localparam logic [3:0] REQ_NEXT         = 4'd0;
  localparam logic [3:0] REQ_PREV         = 4'd1;
  localparam logic [3:0] REQ_SET_PROGRAM  = 4'd2;
  localparam logic [3:0] REQ_SET_PRESET   = 4'd3;
  localparam logic [3:0] REQ_PEND_PROGRAM = 4'd4;
  localparam logic [3:0] REQ_PEND_PRESET  = 4'd5;
  localparam logic [3:0] REQ_CONFIRM      = 4'd6;
  localparam logic [3:0] REQ_CANCEL       = 4'd7;
  localparam logic [3:0] REQ_SET_BANK     = 4'd8;
  localparam logic [3:0] REQ_MIDI_IN      = 4'd9;

  // Message kinds, outgoing and incoming
  localparam logic [1:0] MSG_NONE = 2'd0;
  localparam logic [1:0] MSG_CC   = 2'd1;
  localparam logic [1:0] MSG_PC   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_ARG     = 2'd1;
  localparam logic [1:0] ST_NO_PENDING  = 2'd2;

  // Bank select modes
  localparam logic [1:0] BANK_NONE     = 2'd0;
  localparam logic [1:0] BANK_CC0      = 2'd1;
  localparam logic [1:0] BANK_CC0_CC32 = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_CHANNEL      = 3'd0;
  localparam logic [2:0] CFG_BANK_SCHEME  = 3'd1;
  localparam logic [2:0] CFG_CHANGE_MODE  = 3'd2;
  localparam logic [2:0] CFG_LOW_INDEX    = 3'd3;
  localparam logic [2:0] CFG_PRESET_TOTAL = 3'd4;
  localparam logic [2:0] CFG_WRAP_ENABLE  = 3'd5;

  localparam int CFG_DATA_W = 15;

  // Limits and controller numbers
  localparam logic [13:0] PRESET_CEIL = 14'd16383;
  localparam logic [6:0]  PROG_CEIL   = 7'd127;
  localparam logic [6:0]  CC_BANK_MSB = 7'd0;
  localparam logic [6:0]  CC_BANK_LSB = 7'd32;

  typedef struct packed {
    logic [4:0]  dev_channel;
    logic [1:0]  bank_scheme;
    logic        change_mode;
    logic        low_index;
    logic [14:0] preset_total;
    logic        wrap_enable;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [13:0] value;
    logic [3:0]  in_channel;
    logic [1:0]  in_kind;
    logic [6:0]  in_data1;
    logic [6:0]  in_data2;
  } req_t;

  // Everything the output sequencer needs to play out one request
  typedef struct packed {
    logic        send;
    logic [1:0]  beats;
    logic [3:0]  chan;
    logic [1:0]  status;
    logic [6:0]  cur_program;
    logic [6:0]  cur_bank;
    logic [6:0]  pend_program;
    logic [6:0]  pend_bank;
    logic        pend_valid;
  } res_t;

endpackage

### sv/mpn_cfg.sv
// Configuration register file of the MIDI preset navigator.
module mpn_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_addr,
  input  logic [mpn_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output mpn_pkg::cfg_t                  cfg
);

  mpn_pkg::cfg_t cfg_r, cfg_nxt;

  // Decode the register index and take the low bits of the data
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        mpn_pkg::CFG_CHANNEL:      cfg_nxt.dev_channel  = cfg_wdata[4:0];
        mpn_pkg::CFG_BANK_SCHEME:  cfg_nxt.bank_scheme  = cfg_wdata[1:0];
        mpn_pkg::CFG_CHANGE_MODE:  cfg_nxt.change_mode  = cfg_wdata[0];
        mpn_pkg::CFG_LOW_INDEX:    cfg_nxt.low_index    = cfg_wdata[0];
        mpn_pkg::CFG_PRESET_TOTAL: cfg_nxt.preset_total = cfg_wdata[14:0];
        mpn_pkg::CFG_WRAP_ENABLE:  cfg_nxt.wrap_enable  = cfg_wdata[0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dev_channel  <= 5'd1;
      cfg_r.bank_scheme  <= mpn_pkg::BANK_NONE;
      cfg_r.change_mode  <= 1'b0;
      cfg_r.low_index    <= 1'b0;
      cfg_r.preset_total <= 15'd128;
      cfg_r.wrap_enable  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/mpn_core.sv
// Navigation state and the per-request update logic.
module mpn_core (
  input  logic          clk,
  input  logic          rst_n,
  input  mpn_pkg::cfg_t cfg,
  input  mpn_pkg::req_t req,
  input  logic          load,
  output mpn_pkg::res_t res
);

  logic [6:0] prog_now_r,  prog_now_nxt;
  logic [6:0] bank_now_r,  bank_now_nxt;
  logic [6:0] prog_w_r,    prog_w_nxt;
  logic [6:0] bank_w_r,    bank_w_nxt;
  logic       wflag_r,     wflag_nxt;
  logic [6:0] latch_r,     latch_nxt;
  logic       seen_r,      seen_nxt;

  logic        in_bank;
  logic [3:0]  chan;
  logic [15:0] msum;
  logic [13:0] top_preset;
  logic [6:0]  top_prog;
  logic [13:0] lo;
  logic [13:0] b;
  logic [13:0] hi_step;
  logic [14:0] n_up;
  logic [13:0] n;
  logic [13:0] cv;
  logic        use_preset;
  logic [13:0] hi_c;
  logic [13:0] cl;
  logic        send;
  logic [1:0]  status;

  // Bounds from the configuration
  assign in_bank = cfg.bank_scheme inside {mpn_pkg::BANK_CC0, mpn_pkg::BANK_CC0_CC32};
  assign chan    = cfg.dev_channel[3:0] - 4'd1;
  assign msum    = {15'd0, cfg.low_index} + {1'b0, cfg.preset_total} - 16'd1;

  always_comb begin
    if (cfg.preset_total == 15'd0) begin
      top_preset = in_bank ? mpn_pkg::PRESET_CEIL : {7'd0, mpn_pkg::PROG_CEIL};
    end else if (msum > {2'b00, mpn_pkg::PRESET_CEIL}) begin
      top_preset = mpn_pkg::PRESET_CEIL;
    end else begin
      top_preset = msum[13:0];
    end
  end

  assign top_prog = (top_preset > {7'd0, mpn_pkg::PROG_CEIL}) ? mpn_pkg::PROG_CEIL
                                                             : top_preset[6:0];
  assign lo = {13'd0, cfg.low_index};

  // Step one preset up or down from the pending or current position
  always_comb begin
    if (in_bank) begin
      b       = wflag_r ? {bank_w_r, prog_w_r} : {bank_now_r, prog_now_r};
      hi_step = top_preset;
    end else begin
      b       = {7'd0, (wflag_r ? prog_w_r : prog_now_r)};
      hi_step = {7'd0, top_prog};
    end
    n_up = {1'b0, b} + 15'd1;
    if (req.req_type == mpn_pkg::REQ_NEXT) begin
      if (n_up > {1'b0, hi_step}) n = cfg.wrap_enable ? lo : hi_step;
      else                        n = n_up[13:0];
    end else begin
      if (b <= lo) n = cfg.wrap_enable ? hi_step : lo;
      else         n = b - 14'd1;
    end
  end

  // Shared clamp for program and preset values
  always_comb begin
    case (req.req_type)
      mpn_pkg::REQ_NEXT, mpn_pkg::REQ_PREV: begin
        cv = n;
        use_preset = in_bank;
      end
      mpn_pkg::REQ_SET_PRESET, mpn_pkg::REQ_PEND_PRESET: begin
        cv = req.value;
        use_preset = 1'b1;
      end
      mpn_pkg::REQ_CONFIRM: begin
        cv = {7'd0, prog_w_r};
        use_preset = 1'b0;
      end
      default: begin
        cv = req.value;
        use_preset = 1'b0;
      end
    endcase
    hi_c = use_preset ? top_preset : {7'd0, top_prog};
    cl   = (cv < lo) ? lo : ((cv > hi_c) ? hi_c : cv);
  end

  // Apply the request to the state
  always_comb begin
    prog_now_nxt = prog_now_r;
    bank_now_nxt = bank_now_r;
    prog_w_nxt   = prog_w_r;
    bank_w_nxt   = bank_w_r;
    wflag_nxt    = wflag_r;
    latch_nxt    = latch_r;
    seen_nxt     = seen_r;
    send         = 1'b0;
    status       = mpn_pkg::ST_OK;
    case (req.req_type)
      mpn_pkg::REQ_NEXT, mpn_pkg::REQ_PREV: begin
        if (!cfg.change_mode) begin
          send         = 1'b1;
          prog_now_nxt = cl[6:0];
          if (in_bank) bank_now_nxt = cl[13:7];
        end else begin
          if (in_bank) bank_w_nxt = n[13:7];
          prog_w_nxt = n[6:0];
          wflag_nxt  = 1'b1;
        end
      end
      mpn_pkg::REQ_SET_PROGRAM: begin
        send         = 1'b1;
        prog_now_nxt = cl[6:0];
      end
      mpn_pkg::REQ_SET_PRESET: begin
        send         = 1'b1;
        prog_now_nxt = cl[6:0];
        bank_now_nxt = cl[13:7];
      end
      mpn_pkg::REQ_PEND_PROGRAM: begin
        prog_w_nxt = cl[6:0];
        wflag_nxt  = 1'b1;
      end
      mpn_pkg::REQ_PEND_PRESET: begin
        prog_w_nxt = cl[6:0];
        bank_w_nxt = cl[13:7];
        wflag_nxt  = 1'b1;
      end
      mpn_pkg::REQ_CONFIRM: begin
        if (!wflag_r) begin
          status = mpn_pkg::ST_NO_PENDING;
        end else begin
          send         = 1'b1;
          wflag_nxt    = 1'b0;
          prog_now_nxt = cl[6:0];
          if (in_bank) bank_now_nxt = bank_w_r;
        end
      end
      mpn_pkg::REQ_CANCEL: begin
        if (!wflag_r) begin
          status = mpn_pkg::ST_NO_PENDING;
        end else begin
          wflag_nxt  = 1'b0;
          prog_w_nxt = prog_now_r;
          bank_w_nxt = bank_now_r;
        end
      end
      mpn_pkg::REQ_SET_BANK: begin
        if (req.value > {7'd0, mpn_pkg::PROG_CEIL}) status = mpn_pkg::ST_BAD_ARG;
        else bank_now_nxt = req.value[6:0];
      end
      mpn_pkg::REQ_MIDI_IN: begin
        if (req.in_channel == chan) begin
          if (req.in_kind == mpn_pkg::MSG_CC) begin
            // latch bank MSB for the next program change
            if (in_bank && req.in_data1 == mpn_pkg::CC_BANK_MSB) begin
              latch_nxt = req.in_data2;
              seen_nxt  = 1'b1;
            end
          end else if (req.in_kind == mpn_pkg::MSG_PC) begin
            prog_now_nxt = req.in_data1;
            if (in_bank && seen_r) bank_now_nxt = latch_r;
            latch_nxt = 7'd0;
            seen_nxt  = 1'b0;
            wflag_nxt = 1'b0;
          end
        end
      end
      default: begin
        send = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_now_r <= 7'd0;
      bank_now_r <= 7'd0;
      prog_w_r   <= 7'd0;
      bank_w_r   <= 7'd0;
      wflag_r    <= 1'b0;
      latch_r    <= 7'd0;
      seen_r     <= 1'b0;
    end else if (load) begin
      prog_now_r <= prog_now_nxt;
      bank_now_r <= bank_now_nxt;
      prog_w_r   <= prog_w_nxt;
      bank_w_r   <= bank_w_nxt;
      wflag_r    <= wflag_nxt;
      latch_r    <= latch_nxt;
      seen_r     <= seen_nxt;
    end
  end

  // Result summary handed to the output sequencer
  always_comb begin
    res.send         = send;
    if (!send)                                          res.beats = 2'd1;
    else if (cfg.bank_scheme == mpn_pkg::BANK_CC0)      res.beats = 2'd2;
    else if (cfg.bank_scheme == mpn_pkg::BANK_CC0_CC32) res.beats = 2'd3;
    else                                                res.beats = 2'd1;
    res.chan         = chan;
    res.status       = status;
    res.cur_program  = prog_now_nxt;
    res.cur_bank     = bank_now_nxt;
    res.pend_program = prog_w_nxt;
    res.pend_bank    = bank_w_nxt;
    res.pend_valid   = wflag_nxt;
  end

endmodule

### sv/mpn_emit.sv
// Result register that plays out the one to three beats of a request.
module mpn_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  mpn_pkg::res_t res_in,
  output logic          can_take,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [55:0]   out_tdata,   // channel, number, value, status, cur prog/bank,
                                     // pend prog/bank, pend valid, zero fill
  output logic [1:0]    out_tuser,   // msg_kind
  output logic          out_tlast
);

  mpn_pkg::res_t res_r, res_nxt;
  logic          busy_r, busy_nxt;
  logic [1:0]    beat_r, beat_nxt;
  logic          last_beat;
  logic          out_fire;
  logic [1:0]    kind;
  logic [6:0]    num;
  logic [6:0]    val;
  logic [3:0]    chan_o;

  assign last_beat  = (beat_r == res_r.beats - 2'd1);
  assign out_tvalid = busy_r;
  assign out_fire   = busy_r && out_tready;
  assign can_take   = !busy_r || (out_fire && last_beat);

  // Advance through the beats, reload on the last one or when idle
  always_comb begin
    busy_nxt = busy_r;
    beat_nxt = beat_r;
    res_nxt  = res_r;
    if (load) begin
      res_nxt  = res_in;
      beat_nxt = 2'd0;
      busy_nxt = 1'b1;
    end else if (out_fire) begin
      if (last_beat) busy_nxt = 1'b0;
      else           beat_nxt = beat_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      beat_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      beat_r <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // Beat content: bank MSB, then bank LSB, program change last; status only if no send
  always_comb begin
    if (!res_r.send) begin
      kind = mpn_pkg::MSG_NONE;
      num  = 7'd0;
      val  = 7'd0;
    end else if (last_beat) begin
      kind = mpn_pkg::MSG_PC;
      num  = res_r.cur_program;
      val  = 7'd0;
    end else if (beat_r == 2'd0) begin
      kind = mpn_pkg::MSG_CC;
      num  = mpn_pkg::CC_BANK_MSB;
      val  = res_r.cur_bank;
    end else begin
      kind = mpn_pkg::MSG_CC;
      num  = mpn_pkg::CC_BANK_LSB;
      val  = 7'd0;
    end
    chan_o = res_r.send ? res_r.chan : 4'd0;
  end

  assign out_tuser = kind;
  assign out_tlast = last_beat;
  assign out_tdata = {7'd0, res_r.pend_valid, res_r.pend_bank, res_r.pend_program,
                      res_r.cur_bank, res_r.cur_program, res_r.status, val, num, chan_o};

endmodule

### sv/midi_preset_navigator.sv
// Top level of the MIDI preset navigator: input register, core and output sequencer.
//
// Keeps the current and pending program and bank of one MIDI device and turns
// each request beat into one to three result beats. A request that sends
// nothing yields one status beat; a send yields a program change, led by CC0
// in bank mode 1 and by CC0 plus CC32 in bank mode 2. Requests pass an input
// register and are applied to the core state as the sequencer takes them; the
// output sequencer then plays one result beat per cycle while out_tready is
// high. A new request is taken while the previous one is still being played
// out, as soon as its last beat is going. Configuration writes belong to idle
// periods.
module midi_preset_navigator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // value, in_channel, in_data1,
                                                     // in_data2
  input  logic [5:0]                     in_tuser,   // req_type, in_kind
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [55:0]                    out_tdata,  // msg_channel, msg_number,
                                                     // msg_value, status, cur_program,
                                                     // cur_bank, pend_program,
                                                     // pend_bank, pend_valid, zero fill
  output logic [1:0]                     out_tuser,  // msg_kind
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_addr,
  input  logic [mpn_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  mpn_pkg::cfg_t cfg;
  mpn_pkg::req_t req_r, req_nxt;
  mpn_pkg::res_t res;
  logic          in_valid_r, in_valid_nxt;
  logic          in_fire;
  logic          can_take;
  logic          move;

  mpn_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Hold the request beat until the sequencer can take its results
  assign move      = in_valid_r && can_take;
  assign in_tready = !in_valid_r || move;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    req_nxt = req_r;
    if (in_fire) begin
      req_nxt.req_type   = in_tuser[3:0];
      req_nxt.in_kind    = in_tuser[5:4];
      req_nxt.value      = in_tdata[13:0];
      req_nxt.in_channel = in_tdata[17:14];
      req_nxt.in_data1   = in_tdata[24:18];
      req_nxt.in_data2   = in_tdata[31:25];
    end
    if (in_fire)   in_valid_nxt = 1'b1;
    else if (move) in_valid_nxt = 1'b0;
    else           in_valid_nxt = in_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
  end

  mpn_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .req   (req_r),
    .load  (move),
    .res   (res)
  );

  mpn_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (move),
    .res_in     (res),
    .can_take   (can_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### verif/testbench.sv
// Self-checking testbench for the MIDI preset navigator: stream driver, predictor and monitor.
module testbench;

  localparam int CFG_W = mpn_pkg::CFG_DATA_W;

  // Bank mode code with no name in the package; it acts like no bank select
  localparam logic [1:0] BANK_UNUSED = 2'd3;
  // Request code and incoming kind with no meaning; both are ignored
  localparam logic [3:0] REQ_UNUSED  = 4'd15;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // One result beat as the predictor sees it
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] chan;
    logic [6:0] num;
    logic [6:0] val;
    logic [1:0] status;
    logic [6:0] cur_program;
    logic [6:0] cur_bank;
    logic [6:0] pend_program;
    logic [6:0] pend_bank;
    logic       pend_valid;
    logic       last;
  } beat_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [31:0]      in_tdata = '0;   // value, in_channel, in_data1, in_data2
  logic [5:0]       in_tuser = '0;   // req_type, in_kind
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [55:0]      out_tdata;       // msg_channel, msg_number, msg_value, status,
                                     // cur_program, cur_bank, pend_program, pend_bank,
                                     // pend_valid, zero fill
  logic [1:0]       out_tuser;       // msg_kind
  logic             out_tlast;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  midi_preset_navigator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Mirror of the registers and of the navigator state
  mpn_pkg::cfg_t regs;
  logic [6:0] prog_now = '0, bank_now = '0, prog_wait = '0, bank_wait = '0, msb_latch = '0;
  logic       wait_flag = 1'b0, msb_seen = 1'b0;

  // Messages sent by the request being predicted
  logic [1:0] send_kind[3];
  logic [6:0] send_num[3];
  logic [6:0] send_val[3];
  int         send_cnt;

  mpn_pkg::req_t req_backlog[$];
  beat_t         beats_due[$];
  int            mismatches = 0;
  int            requests_taken = 0;
  int            beats_checked = 0;
  int            pc_beats = 0;
  int            cc_beats = 0;
  int            settings_used = 0;

  function automatic bit bank_sel();
    return regs.bank_scheme inside {mpn_pkg::BANK_CC0, mpn_pkg::BANK_CC0_CC32};
  endfunction

  function automatic logic [3:0] dev_chan();
    return 4'(regs.dev_channel + 5'd15);
  endfunction

  function automatic int unsigned preset_hi();
    int unsigned m;
    if (regs.preset_total == 0) begin
      return bank_sel() ? int'(mpn_pkg::PRESET_CEIL) : int'(mpn_pkg::PROG_CEIL);
    end
    m = int'(regs.low_index) + int'(regs.preset_total) - 1;
    return (m > mpn_pkg::PRESET_CEIL) ? int'(mpn_pkg::PRESET_CEIL) : m;
  endfunction

  function automatic int unsigned prog_hi();
    int unsigned m;
    m = preset_hi();
    return (m > mpn_pkg::PROG_CEIL) ? int'(mpn_pkg::PROG_CEIL) : m;
  endfunction

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  task automatic add_msg(input logic [1:0] kind, input logic [6:0] num, input logic [6:0] val);
    if (send_cnt < 3) begin
      send_kind[send_cnt] = kind;
      send_num[send_cnt] = num;
      send_val[send_cnt] = val;
      send_cnt++;
    end
  endtask

  // Program change, led by the bank select controllers the bank mode calls for
  task automatic queue_send(input logic [6:0] bank, input logic [6:0] prog);
    if (bank_sel()) add_msg(mpn_pkg::MSG_CC, mpn_pkg::CC_BANK_MSB, bank);
    if (regs.bank_scheme == mpn_pkg::BANK_CC0_CC32) begin
      add_msg(mpn_pkg::MSG_CC, mpn_pkg::CC_BANK_LSB, 7'd0);
    end
    add_msg(mpn_pkg::MSG_PC, prog, 7'd0);
  endtask

  task automatic set_program(input int unsigned v);
    prog_now = 7'(clamp_to(v, regs.low_index, prog_hi()));
    queue_send(bank_now, prog_now);
  endtask

  task automatic set_preset(input int unsigned v);
    int unsigned p;
    p = clamp_to(v, regs.low_index, preset_hi());
    bank_now = 7'(p >> 7);
    prog_now = 7'(p);
    queue_send(bank_now, prog_now);
  endtask

  // Step from the pending preset if one waits, else from the current one
  task automatic step(input bit up);
    int unsigned lo, hi, b, n;
    lo = regs.low_index;
    if (bank_sel()) begin
      hi = preset_hi();
      b = wait_flag ? int'(bank_wait) * 128 + int'(prog_wait)
                    : int'(bank_now) * 128 + int'(prog_now);
    end else begin
      hi = prog_hi();
      b = wait_flag ? int'(prog_wait) : int'(prog_now);
    end
    if (up) begin
      n = b + 1;
      if (n > hi) n = regs.wrap_enable ? lo : hi;
    end else if (b <= lo) begin
      n = regs.wrap_enable ? hi : lo;
    end else begin
      n = b - 1;
    end
    if (regs.change_mode == 1'b0) begin
      if (bank_sel()) set_preset(n);
      else set_program(n);
    end else begin
      if (bank_sel()) bank_wait = 7'(n >> 7);
      prog_wait = 7'(n);
      wait_flag = 1'b1;
    end
  endtask

  // Advance the mirror by one request and queue the beats it must produce
  task automatic apply_request(input mpn_pkg::req_t r);
    logic [1:0] status;
    int unsigned p;
    beat_t bt;
    send_cnt = 0;
    status = mpn_pkg::ST_OK;
    case (r.req_type)
      mpn_pkg::REQ_NEXT:        step(1'b1);
      mpn_pkg::REQ_PREV:        step(1'b0);
      mpn_pkg::REQ_SET_PROGRAM: set_program(r.value);
      mpn_pkg::REQ_SET_PRESET:  set_preset(r.value);
      mpn_pkg::REQ_PEND_PROGRAM: begin
        prog_wait = 7'(clamp_to(r.value, regs.low_index, prog_hi()));
        wait_flag = 1'b1;
      end
      mpn_pkg::REQ_PEND_PRESET: begin
        p = clamp_to(r.value, regs.low_index, preset_hi());
        bank_wait = 7'(p >> 7);
        prog_wait = 7'(p);
        wait_flag = 1'b1;
      end
      mpn_pkg::REQ_CONFIRM: begin
        if (!wait_flag) begin
          status = mpn_pkg::ST_NO_PENDING;
        end else begin
          wait_flag = 1'b0;
          if (bank_sel()) bank_now = bank_wait;
          set_program(prog_wait);
        end
      end
      mpn_pkg::REQ_CANCEL: begin
        if (!wait_flag) begin
          status = mpn_pkg::ST_NO_PENDING;
        end else begin
          wait_flag = 1'b0;
          prog_wait = prog_now;
          bank_wait = bank_now;
        end
      end
      mpn_pkg::REQ_SET_BANK: begin
        if (r.value > mpn_pkg::PROG_CEIL) status = mpn_pkg::ST_BAD_ARG;
        else bank_now = 7'(r.value);
      end
      mpn_pkg::REQ_MIDI_IN: begin
        if (r.in_channel == dev_chan()) begin
          if (r.in_kind == mpn_pkg::MSG_CC) begin
            if (bank_sel() && r.in_data1 == mpn_pkg::CC_BANK_MSB) begin
              msb_latch = r.in_data2;
              msb_seen = 1'b1;
            end
          end else if (r.in_kind == mpn_pkg::MSG_PC) begin
            prog_now = r.in_data1;
            if (bank_sel() && msb_seen) bank_now = msb_latch;
            msb_latch = '0;
            msb_seen = 1'b0;
            wait_flag = 1'b0;
          end
        end
      end
      default: ;
    endcase

    // Status-only beat when nothing goes out
    if (send_cnt == 0) add_msg(mpn_pkg::MSG_NONE, 7'd0, 7'd0);
    for (int k = 0; k < send_cnt; k++) begin
      bt.kind = send_kind[k];
      bt.chan = (send_kind[k] != mpn_pkg::MSG_NONE) ? dev_chan() : 4'd0;
      bt.num = send_num[k];
      bt.val = send_val[k];
      bt.status = status;
      bt.cur_program = prog_now;
      bt.cur_bank = bank_now;
      bt.pend_program = prog_wait;
      bt.pend_bank = bank_wait;
      bt.pend_valid = wait_flag;
      bt.last = (k == send_cnt - 1);
      beats_due.push_back(bt);
    end
  endtask

  // Driver: bursts of request beats separated by random gaps
  mpn_pkg::req_t on_bus;
  int            burst_left = 1;
  int            gap_left = 0;

  always @(posedge clk) begin : drive_requests
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_request(on_bus);
        requests_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          on_bus = req_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= {on_bus.in_kind, on_bus.req_type};
          in_tdata <= {on_bus.in_data2, on_bus.in_data1, on_bus.in_channel, on_bus.value};
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: always ready, coin flips, one in four, or stall_ctr bit 3 low
  int         ready_mode = 0;
  int         ready_left = 0;
  logic [3:0] stall_ctr = '0;

  always @(posedge clk) begin : stall_pattern
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(20, 80);
    end else begin
      ready_left--;
    end
    stall_ctr = stall_ctr + 4'd1;
    case (ready_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= (stall_ctr[1:0] == 2'd0);
      default: out_tready <= ~stall_ctr[3];
    endcase
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: compare each result beat against the oldest prediction
  always @(posedge clk) begin : check_results
    beat_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser;
      got.chan = out_tdata[3:0];
      got.num = out_tdata[10:4];
      got.val = out_tdata[17:11];
      got.status = out_tdata[19:18];
      got.cur_program = out_tdata[26:20];
      got.cur_bank = out_tdata[33:27];
      got.pend_program = out_tdata[40:34];
      got.pend_bank = out_tdata[47:41];
      got.pend_valid = out_tdata[48];
      got.last = out_tlast;
      if (beats_due.size() == 0) begin
        $error("result beat with nothing expected: msg_kind %0d", got.kind);
        mismatches++;
      end else begin
        want = beats_due.pop_front();
        check_field("msg_kind", want.kind, got.kind);
        check_field("msg_channel", want.chan, got.chan);
        check_field("msg_number", want.num, got.num);
        check_field("msg_value", want.val, got.val);
        check_field("status", want.status, got.status);
        check_field("cur_program", want.cur_program, got.cur_program);
        check_field("cur_bank", want.cur_bank, got.cur_bank);
        check_field("pend_program", want.pend_program, got.pend_program);
        check_field("pend_bank", want.pend_bank, got.pend_bank);
        check_field("pend_valid", want.pend_valid, got.pend_valid);
        check_field("last", want.last, got.last);
        beats_checked++;
        if (want.kind == mpn_pkg::MSG_PC) pc_beats++;
        if (want.kind == mpn_pkg::MSG_CC) cc_beats++;
      end
    end
  end

  // Stimulus
  task automatic push_req(input logic [3:0] kind, input int unsigned value,
                          input logic [3:0] ch, input logic [1:0] ikind,
                          input logic [6:0] d1, input logic [6:0] d2);
    mpn_pkg::req_t r;
    r.req_type = kind;
    r.value = 14'(value);
    r.in_channel = ch;
    r.in_kind = ikind;
    r.in_data1 = d1;
    r.in_data2 = d2;
    req_backlog.push_back(r);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      mpn_pkg::CFG_CHANNEL:      regs.dev_channel = val[4:0];
      mpn_pkg::CFG_BANK_SCHEME:  regs.bank_scheme = val[1:0];
      mpn_pkg::CFG_CHANGE_MODE:  regs.change_mode = val[0];
      mpn_pkg::CFG_LOW_INDEX:    regs.low_index = val[0];
      mpn_pkg::CFG_PRESET_TOTAL: regs.preset_total = val;
      mpn_pkg::CFG_WRAP_ENABLE:  regs.wrap_enable = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned ch, input logic [1:0] bm, input bit cm,
                            input bit ib, input int unsigned total, input bit wrap);
    write_reg(mpn_pkg::CFG_CHANNEL, CFG_W'(ch));
    write_reg(mpn_pkg::CFG_BANK_SCHEME, CFG_W'(bm));
    write_reg(mpn_pkg::CFG_CHANGE_MODE, CFG_W'(cm));
    write_reg(mpn_pkg::CFG_LOW_INDEX, CFG_W'(ib));
    write_reg(mpn_pkg::CFG_PRESET_TOTAL, CFG_W'(total));
    write_reg(mpn_pkg::CFG_WRAP_ENABLE, CFG_W'(wrap));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Hold until every request is taken and every beat has come back
  task automatic wait_idle();
    do @(posedge clk);
    while (req_backlog.size() != 0 || in_tvalid || beats_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [13:0] rand_value();
    case ($urandom_range(0, 4))
      0:       return 14'($urandom_range(0, 140));
      1:       return 14'($urandom_range(16300, 16383));
      2:       return 14'($urandom_range(0, 16383));
      3:       return 14'($urandom_range(125, 130));
      default: return 14'($urandom_range(0, 600));
    endcase
  endfunction

  task automatic random_items(input int n);
    mpn_pkg::req_t r;
    int pick;
    int added;
    added = 0;
    while (added < n) begin
      // Start from noise in every field, then shape the request
      r.req_type = 4'($urandom_range(0, 15));
      r.value = 14'($urandom_range(0, 16383));
      r.in_channel = 4'($urandom_range(0, 15));
      r.in_kind = 2'($urandom_range(0, 3));
      r.in_data1 = 7'($urandom_range(0, 127));
      r.in_data2 = 7'($urandom_range(0, 127));
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        // Bank select followed by program change on the device channel
        r.req_type = mpn_pkg::REQ_MIDI_IN;
        r.in_channel = dev_chan();
        r.in_kind = mpn_pkg::MSG_CC;
        r.in_data1 = mpn_pkg::CC_BANK_MSB;
        req_backlog.push_back(r);
        added++;
        if ($urandom_range(0, 1)) begin
          r.in_data1 = mpn_pkg::CC_BANK_LSB;
          r.in_data2 = 7'($urandom_range(0, 127));
          req_backlog.push_back(r);
          added++;
        end
        r.in_kind = mpn_pkg::MSG_PC;
        r.in_data1 = 7'($urandom_range(0, 127));
      end else if (pick < 40) begin
        r.req_type = $urandom_range(0, 1) ? mpn_pkg::REQ_NEXT : mpn_pkg::REQ_PREV;
      end else if (pick < 55) begin
        r.req_type = $urandom_range(0, 1) ? mpn_pkg::REQ_SET_PROGRAM : mpn_pkg::REQ_SET_PRESET;
        r.value = rand_value();
      end else if (pick < 65) begin
        r.req_type = $urandom_range(0, 1) ? mpn_pkg::REQ_PEND_PROGRAM
                                          : mpn_pkg::REQ_PEND_PRESET;
        r.value = rand_value();
      end else if (pick < 75) begin
        r.req_type = $urandom_range(0, 2) ? mpn_pkg::REQ_CONFIRM : mpn_pkg::REQ_CANCEL;
      end else if (pick < 83) begin
        r.req_type = mpn_pkg::REQ_SET_BANK;
        if ($urandom_range(0, 3) != 0) r.value = 14'($urandom_range(0, 127));
      end else if (pick < 96) begin
        r.req_type = mpn_pkg::REQ_MIDI_IN;
        if ($urandom_range(0, 9) < 7) r.in_channel = dev_chan();
        case ($urandom_range(0, 4))
          0, 1: r.in_data1 = mpn_pkg::CC_BANK_MSB;
          2:    r.in_data1 = mpn_pkg::CC_BANK_LSB;
          default: ;
        endcase
      end else begin
        r.req_type = 4'($urandom_range(10, 15));
      end
      req_backlog.push_back(r);
      added++;
    end
  endtask

  int unsigned chan_pick[8] = '{1, 16, 0, 31, 17, 9, 2, 5};
  logic [1:0]  bank_pick[8] = '{mpn_pkg::BANK_NONE, mpn_pkg::BANK_CC0,
                                mpn_pkg::BANK_CC0_CC32, BANK_UNUSED,
                                mpn_pkg::BANK_CC0, mpn_pkg::BANK_CC0_CC32,
                                mpn_pkg::BANK_NONE, mpn_pkg::BANK_CC0_CC32};
  int unsigned total_pick[8] = '{128, 1, 16384, 0, 32767, 2, 300, 129};

  initial begin : run_phases
    int unsigned ch, total;
    logic [2:0] sel;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: clamping, pending, status codes and incoming program change
    set_config(1, mpn_pkg::BANK_NONE, 1'b0, 1'b0, 128, 1'b0);
    push_req(mpn_pkg::REQ_SET_PROGRAM, 0, 4'd0, mpn_pkg::MSG_NONE, 7'd0, 7'd0);
    push_req(mpn_pkg::REQ_SET_PROGRAM, 16383, 4'd15, KIND_UNUSED, 7'd127, 7'd127);
    push_req(mpn_pkg::REQ_NEXT, 0, 4'd0, mpn_pkg::MSG_NONE, 7'd0, 7'd0);
    push_req(mpn_pkg::REQ_PREV, 0, 4'd0, mpn_pkg::MSG_NONE, 7'd0, 7'd0);
    push_req(mpn_pkg::REQ_SET_PRESET, 16383, 4'd0, mpn_pkg::MSG_NONE, 7'd0, 7'd0);
    push_req(mpn_pkg::REQ_PEND_PROGRAM, 5, 4'd0, mpn_pkg::MSG_NONE, 7'd0, 7'd0);
    push_req(mpn_pkg::REQ_CONFIRM, 0, 4'd0, mpn_pkg::MSG_NONE, 7'd0, 7'd0);
    push_req(mpn_pkg::REQ_CONFIRM, 0, 4'd0, mpn_pkg::MSG_NONE, 7'd0, 7'd0);
    push_req(mpn_pkg::REQ_PEND_PRESET, 200, 4'd0, mpn_pkg::MSG_NONE, 7'd0, 7'd0);
    push_req(mpn_pkg::REQ_CANCEL, 0, 4'd0, mpn_pkg::MSG_NONE, 7'd0, 7'd0);
    push_req(mpn_pkg::REQ_CANCEL, 0, 4'd0, mpn_pkg::MSG_NONE, 7'd0, 7'd0);
    push_req(mpn_pkg::REQ_SET_BANK, 127, 4'd0, mpn_pkg::MSG_NONE, 7'd0, 7'd0);
    push_req(mpn_pkg::REQ_SET_BANK, 128, 4'd0, mpn_pkg::MSG_NONE, 7'd0, 7'd0);
    push_req(mpn_pkg::REQ_MIDI_IN, 0, 4'd0, mpn_pkg::MSG_PC, 7'd127, 7'd0);
    wait_idle();

    // Full bank select, pending steps with wrap, zero total, channel 16 and incoming bank
    set_config(16, mpn_pkg::BANK_CC0_CC32, 1'b1, 1'b1, 0, 1'b1);
    push_req(mpn_pkg::REQ_PEND_PRESET, 16383, 4'd0, mpn_pkg::MSG_NONE, 7'd0, 7'd0);
    push_req(mpn_pkg::REQ_NEXT, 0, 4'd0, mpn_pkg::MSG_NONE, 7'd0, 7'd0);
    push_req(mpn_pkg::REQ_PREV, 0, 4'd0, mpn_pkg::MSG_NONE, 7'd0, 7'd0);
    push_req(mpn_pkg::REQ_CONFIRM, 0, 4'd0, mpn_pkg::MSG_NONE, 7'd0, 7'd0);
    push_req(mpn_pkg::REQ_MIDI_IN, 0, 4'd15, mpn_pkg::MSG_CC, mpn_pkg::CC_BANK_MSB, 7'd127);
    push_req(mpn_pkg::REQ_MIDI_IN, 0, 4'd15, mpn_pkg::MSG_CC, mpn_pkg::CC_BANK_LSB, 7'd0);
    push_req(mpn_pkg::REQ_MIDI_IN, 0, 4'd14, mpn_pkg::MSG_PC, 7'd3, 7'd0);
    push_req(mpn_pkg::REQ_MIDI_IN, 0, 4'd15, KIND_UNUSED, 7'd3, 7'd0);
    push_req(mpn_pkg::REQ_MIDI_IN, 0, 4'd15, mpn_pkg::MSG_PC, 7'd0, 7'd0);
    push_req(mpn_pkg::REQ_SET_PRESET, 0, 4'd0, mpn_pkg::MSG_NONE, 7'd0, 7'd0);
    push_req(REQ_UNUSED, 16383, 4'd15, KIND_UNUSED, 7'd127, 7'd127);
    wait_idle();

    // Random phases, each under a fresh group of settings
    for (int p = 0; p < 8; p++) begin
      sel = 3'(p);
      ch = chan_pick[p];
      total = total_pick[p];
      if (p >= 6) begin
        ch = $urandom_range(0, 31);
        total = $urandom_range(1, 20000);
      end
      set_config(ch, bank_pick[p], sel[0], sel[1], total, sel[2]);
      random_items(30);
      wait_idle();
    end

    $display("Covered %0d requests under %0d register settings.", requests_taken, settings_used);
    $display("Checked %0d result beats: %0d program changes, %0d bank selects.",
             beats_checked, pc_beats, cc_beats);
    if (mismatches == 0) begin
      $display("midi_preset_navigator: match");
    end else begin
      $display("midi_preset_navigator: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin : watchdog
    #200000;
    $display("midi_preset_navigator: mismatch");
    $finish;
  end

endmodule

### midi_preset_navigator.f
sv/mpn_pkg.sv
sv/mpn_cfg.sv
sv/mpn_core.sv
sv/mpn_emit.sv
sv/midi_preset_navigator.sv
verif/testbench.sv
